// ===== src/mdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mdfs_pkg
// Shared types and constants for the marker-delimited frame splitter.
// ----------------------------------------------------------------------------
package mdfs_pkg;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_TELEMETRY = 2'd1,
    KIND_ERROR     = 2'd2
  } item_kind_t;

  typedef enum logic {
    SEQ_IDLE  = 1'b0,
    SEQ_BURST = 1'b1
  } seq_state_t;

  localparam int MARKER_MAX = 32;

  // "This is the end!" then zero fill
  localparam logic [7:0] MARKER_TEXT [MARKER_MAX] = '{
    8'h54, 8'h68, 8'h69, 8'h73, 8'h20, 8'h69, 8'h73, 8'h20,
    8'h74, 8'h68, 8'h65, 8'h20, 8'h65, 8'h6e, 8'h64, 8'h21,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

// ===== src/mdfs_marker_track.sv =====
// ----------------------------------------------------------------------------
// mdfs_marker_track
// Tracks which marker prefixes end at the newest word of the current frame
// and flags a complete marker on the word being accepted.
// ----------------------------------------------------------------------------
module mdfs_marker_track #(
  parameter int MARKER_LENGTH = 17
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] in_byte,
  output logic       match
);
  import mdfs_pkg::*;

  // bit k: last k+1 words of the frame equal the first k+1 marker words
  logic [MARKER_LENGTH-2:0] pm_r;
  logic [MARKER_LENGTH-2:0] pm_nxt;
  logic [MARKER_LENGTH-1:0] hit;

  for (genvar k = 0; k < MARKER_LENGTH; k++) begin : g_cmp
    assign hit[k] = (in_byte == MARKER_TEXT[k]);
  end

  assign pm_nxt[0] = hit[0];
  for (genvar k = 1; k < MARKER_LENGTH - 1; k++) begin : g_pm
    assign pm_nxt[k] = pm_r[k-1] & hit[k];
  end

  assign match = pm_r[MARKER_LENGTH-2] & hit[MARKER_LENGTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r <= '0;
    end else if (step) begin
      pm_r <= match ? '0 : pm_nxt;
    end
  end

endmodule

// ===== src/marker_delimited_frame_splitter.sv =====
// ----------------------------------------------------------------------------
// marker_delimited_frame_splitter
// Splits a byte stream into frames closed by a fixed end marker, passing
// payload words through and emitting the telemetry trailer before the marker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_stream_byte takes one word per cycle while in_stall is low.
//   Output channel out_valid/out_stall carries out_item_kind, out_byte and
//   out_frame_end. The last MARKER_LENGTH+TRAILER_LENGTH-1 words of a frame
//   sit in a circular buffer memory; older words leave as payload.
//   An accepted word reaches the outputs through the memory read register
//   and then the output register. Throughput: one word per cycle unless
//   out_stall or a trailer read holds input off. A marker closing a full
//   frame reads its trailer from the buffer memory one word per cycle
//   through its single read port while the output is not stalled, holding
//   input off meanwhile; a short frame gives one error result, no hold-off.
//   Reset empties the buffer and clears the marker tracker; the buffer
//   memory contents are not cleared and no clearing pass is needed.
//   When the receiver stalls, the output register holds its word, one more
//   result waits in the middle stage, and in_stall rises after that.
// ----------------------------------------------------------------------------
module marker_delimited_frame_splitter #(
  parameter int MARKER_LENGTH  = 17,
  parameter int TRAILER_LENGTH = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_stream_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);
  import mdfs_pkg::*;

  localparam int HOLD  = MARKER_LENGTH + TRAILER_LENGTH - 1;
  localparam int AW    = $clog2(HOLD + 1);
  localparam int DEPTH = 1 << AW;
  localparam int HW    = $clog2(HOLD + 1);
  localparam int TW    = $clog2(TRAILER_LENGTH + 1);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [AW-1:0] ba_r, ba_nxt;
  logic [TW-1:0] idx_r, idx_nxt;
  seq_state_t    state_r, state_nxt;

  logic       s1_valid_r;
  item_kind_t s1_kind_r;
  logic       s1_end_r;
  logic       s1_mem_r;

  logic       out_valid_r;
  item_kind_t out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_end_r;

  logic          accept;
  logic          match;
  logic          full;
  logic          en_out;
  logic          s1_ld;
  logic          iss_valid;
  item_kind_t    iss_kind;
  logic          iss_end;
  logic          iss_mem;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] oldest;

  mdfs_marker_track #(
    .MARKER_LENGTH(MARKER_LENGTH)
  ) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (accept),
    .in_byte(in_stream_byte),
    .match  (match)
  );

  assign en_out   = !out_valid_r || !out_stall;
  assign s1_ld    = !s1_valid_r || en_out;
  assign in_stall = (state_r == SEQ_BURST) || !s1_ld;
  assign accept   = in_valid && !in_stall;
  assign full     = (held_r == HW'(HOLD));
  assign oldest   = wp_r - AW'(HOLD);

  always_comb begin
    iss_valid = 1'b0;
    iss_kind  = KIND_PAYLOAD;
    iss_end   = 1'b0;
    iss_mem   = 1'b0;
    rd_addr   = oldest;
    state_nxt = state_r;
    ba_nxt    = ba_r;
    idx_nxt   = idx_r;
    wp_nxt    = wp_r;
    held_nxt  = held_r;
    unique case (state_r)
      SEQ_BURST: begin
        if (s1_ld) begin
          iss_valid = 1'b1;
          iss_kind  = KIND_TELEMETRY;
          iss_mem   = 1'b1;
          rd_addr   = ba_r;
          iss_end   = (idx_r == TW'(TRAILER_LENGTH - 1));
          ba_nxt    = ba_r + AW'(1);
          idx_nxt   = idx_r + TW'(1);
          if (iss_end) begin
            state_nxt = SEQ_IDLE;
          end
        end
      end
      SEQ_IDLE: begin
        if (accept) begin
          wp_nxt = wp_r + AW'(1);
          if (match) begin
            held_nxt  = '0;
            iss_valid = 1'b1;
            if (full) begin
              iss_kind = KIND_TELEMETRY;
              iss_mem  = 1'b1;
              iss_end  = (TRAILER_LENGTH == 1);
              ba_nxt   = oldest + AW'(1);
              idx_nxt  = TW'(1);
              if (TRAILER_LENGTH > 1) begin
                state_nxt = SEQ_BURST;
              end
            end else begin
              iss_kind = KIND_ERROR;
              iss_end  = 1'b1;
            end
          end else if (full) begin
            iss_valid = 1'b1;
            iss_kind  = KIND_PAYLOAD;
            iss_mem   = 1'b1;
          end else begin
            held_nxt = held_r + HW'(1);
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      held_r      <= '0;
      ba_r        <= '0;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      held_r <= held_nxt;
      ba_r   <= ba_nxt;
      idx_r  <= idx_nxt;
      if (s1_ld) begin
        s1_valid_r <= iss_valid;
      end
      if (en_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp_r] <= in_stream_byte;
    end
    if (s1_ld) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_kind_r <= iss_kind;
      s1_end_r  <= iss_end;
      s1_mem_r  <= iss_mem;
    end
    if (en_out) begin
      out_kind_r <= s1_kind_r;
      out_byte_r <= s1_mem_r ? mem_q : 8'h00;
      out_end_r  <= s1_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item_kind = out_kind_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule
